>>> hw/rtl/fcbe_pkg.sv
package fcbe_pkg;

    // sizing defaults for the top level parameters
    localparam int MAX_PARITY_BITS  = 24;
    localparam int BLOCK_COUNT_BITS = 12;

    // register field widths
    localparam int GEN_W      = 25;
    localparam int PLEN_W     = 5;
    localparam int PAYLEN_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_LEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN    = 2'd2;

    // register reset values
    localparam logic [GEN_W-1:0]    GEN_RESET    = 25'd119;
    localparam logic [PLEN_W-1:0]   PLEN_RESET   = 5'd6;
    localparam logic [PAYLEN_W-1:0] PAYLEN_RESET = 12'd6;

    // result bytes kept per input byte
    localparam int MAX_OUT_PER_ITEM = 4;
    localparam int OUT_CNT_W        = 3;

    localparam int IN_QUEUE_DEPTH  = 2;
    localparam int OUT_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [GEN_W-1:0]    gen;
        logic [PLEN_W-1:0]   plen;
        logic [PAYLEN_W-1:0] paylen;
    } cfg_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } result_t;

endpackage

>>> hw/rtl/fire_code_byte_stream_encoder_core.sv
// channel  | signals                                      | request taken when
// ---------+----------------------------------------------+------------------------
// input    | push, full, data_byte                        | push && !full
// result   | pop, empty, code_byte, run_last              | pop && !empty
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data    | cfg_valid && cfg_ready
//
// the encoder core moves one codeword bit per cycle, unless stalled, through a bit-serial lfsr:
// an input byte sends its eight information bits plus the clamped parity bits of every block it ends
// a two-entry input queue and a four-entry result queue decouple both sides,
// so bytes are taken back to back while results wait to be popped
// a full result queue stalls the bit engine; cfg_ready is always high
// reset clears the lfsr, counters and queues and restores register defaults
module fire_code_byte_stream_encoder_core #(
    parameter int MAX_PARITY_BITS  = fcbe_pkg::MAX_PARITY_BITS,
    parameter int BLOCK_COUNT_BITS = fcbe_pkg::BLOCK_COUNT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        data_byte,
    input  logic                              pop,
    output logic                              empty,
    output logic [7:0]                        code_byte,
    output logic                              run_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fcbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fcbe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [fcbe_pkg::GEN_W-1:0]    gen_reg;
    logic [fcbe_pkg::PLEN_W-1:0]   plen_reg;
    logic [fcbe_pkg::PAYLEN_W-1:0] paylen_reg;
    fcbe_pkg::cfg_t                cfg;
    logic                          cfg_wr;

    logic                          iq_empty;
    logic [7:0]                    iq_byte;
    logic                          iq_pop;
    logic                          oq_push;
    logic                          oq_full;
    fcbe_pkg::result_t             oq_wdata;
    fcbe_pkg::result_t             oq_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg    <= fcbe_pkg::GEN_RESET;
            plen_reg   <= fcbe_pkg::PLEN_RESET;
            paylen_reg <= fcbe_pkg::PAYLEN_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                fcbe_pkg::CFG_GENERATOR_POLY: gen_reg    <= cfg_data[fcbe_pkg::GEN_W-1:0];
                fcbe_pkg::CFG_PARITY_LEN:     plen_reg   <= cfg_data[fcbe_pkg::PLEN_W-1:0];
                fcbe_pkg::CFG_PAYLOAD_LEN:    paylen_reg <= cfg_data[fcbe_pkg::PAYLEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.gen    = gen_reg;
    assign cfg.plen   = plen_reg;
    assign cfg.paylen = paylen_reg;

    fcbe_fifo #(
        .WIDTH (8),
        .DEPTH (fcbe_pkg::IN_QUEUE_DEPTH)
    ) u_in_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (data_byte),
        .full  (full),
        .pop   (iq_pop),
        .rdata (iq_byte),
        .empty (iq_empty)
    );

    fcbe_engine #(
        .MAX_PARITY_BITS  (MAX_PARITY_BITS),
        .BLOCK_COUNT_BITS (BLOCK_COUNT_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (!iq_empty),
        .in_byte  (iq_byte),
        .in_pop   (iq_pop),
        .out_push (oq_push),
        .out_data (oq_wdata),
        .out_full (oq_full)
    );

    fcbe_fifo #(
        .WIDTH ($bits(fcbe_pkg::result_t)),
        .DEPTH (fcbe_pkg::OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (oq_wdata),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty)
    );

    assign code_byte = oq_rdata.code;
    assign run_last  = oq_rdata.last;

endmodule

>>> hw/rtl/fcbe_fifo.sv
module fcbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> hw/rtl/fcbe_engine.sv
module fcbe_engine #(
    parameter int MAX_PARITY_BITS  = fcbe_pkg::MAX_PARITY_BITS,
    parameter int BLOCK_COUNT_BITS = fcbe_pkg::BLOCK_COUNT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fcbe_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_pop,
    output logic                out_push,
    output fcbe_pkg::result_t   out_data,
    input  logic                out_full
);

    localparam int MPB = MAX_PARITY_BITS;
    localparam int BCB = BLOCK_COUNT_BITS;
    localparam int PW  = $clog2(MPB + 1);
    localparam int IW  = $clog2(MPB);
    localparam int OCW = fcbe_pkg::OUT_CNT_W;

    // current input byte and its progress
    logic           busy_reg, busy_next;
    logic [7:0]     byte_reg, byte_next;
    logic [3:0]     info_left_reg, info_left_next;
    logic [OCW-1:0] out_cnt_reg, out_cnt_next;
    // parity lfsr and block position
    logic [MPB-1:0] rem_reg, rem_next;
    logic [BCB-1:0] blk_cnt_reg, blk_cnt_next;
    logic           par_mode_reg, par_mode_next;
    logic [PW-1:0]  par_left_reg, par_left_next;
    // byte packer
    logic [6:0]     pend_reg, pend_next;
    logic [2:0]     pcnt_reg, pcnt_next;
    // last formed byte, held until we know whether it ends its input
    logic [7:0]     stg_byte_reg, stg_byte_next;
    logic           stg_v_reg, stg_v_next;
    logic           stg_closed_reg, stg_closed_next;

    logic [PW-1:0]        r_eff;
    logic [31:0]          plen_w;
    logic [MPB-1:0]       rmask;
    logic [MPB+fcbe_pkg::GEN_W-1:0] gen_x;
    logic [MPB-1:0]       gen_w;
    logic [BCB+fcbe_pkg::PAYLEN_W-1:0] pay_x;
    logic [BCB-1:0]       pay_w;
    logic [IW-1:0]        top_idx;
    logic [PW-1:0]        par_left_m1;
    logic [BCB-1:0]       cnt_inc;
    logic                 bit_v, bit_val, fb, blk_end, item_end;
    logic                 byte_done, new_v, push_need, stall, ld;
    logic [7:0]           new_byte;

    // effective parity length, clamped to the supported range
    assign plen_w = 32'(cfg.plen);
    always_comb
    begin
        if (plen_w < 32'd2)
        begin
            r_eff = PW'(2);
        end
        else if (plen_w > 32'(MPB))
        begin
            r_eff = PW'(MPB);
        end
        else
        begin
            r_eff = PW'(cfg.plen);
        end
    end

    assign rmask       = {MPB{1'b1}} >> (PW'(MPB) - r_eff);
    assign gen_x       = {{MPB{1'b0}}, cfg.gen};
    assign gen_w       = gen_x[MPB-1:0] & rmask;
    assign pay_x       = {{BCB{1'b0}}, cfg.paylen};
    assign pay_w       = pay_x[BCB-1:0];
    assign top_idx     = IW'(r_eff - 1'b1);
    assign par_left_m1 = par_left_reg - 1'b1;
    assign cnt_inc     = blk_cnt_reg + 1'b1;

    always_comb
    begin
        busy_next       = busy_reg;
        byte_next       = byte_reg;
        info_left_next  = info_left_reg;
        out_cnt_next    = out_cnt_reg;
        rem_next        = rem_reg;
        blk_cnt_next    = blk_cnt_reg;
        par_mode_next   = par_mode_reg;
        par_left_next   = par_left_reg;
        pend_next       = pend_reg;
        pcnt_next       = pcnt_reg;
        stg_byte_next   = stg_byte_reg;
        stg_v_next      = stg_v_reg;
        stg_closed_next = stg_closed_reg;
        bit_v           = 1'b0;
        bit_val         = 1'b0;
        fb              = 1'b0;
        blk_end         = 1'b0;
        item_end        = 1'b0;

        // one codeword bit per cycle unless stalled: information first, then parity
        if (busy_reg)
        begin
            bit_v = 1'b1;
            if (par_mode_reg)
            begin
                bit_val       = rem_reg[par_left_m1[IW-1:0]];
                par_left_next = par_left_m1;
                if (par_left_reg == PW'(1))
                begin
                    par_mode_next = 1'b0;
                    rem_next      = '0;
                    item_end      = (info_left_reg == 4'd0);
                end
            end
            else
            begin
                bit_val        = byte_reg[7];
                byte_next      = {byte_reg[6:0], 1'b0};
                info_left_next = info_left_reg - 1'b1;
                fb             = bit_val ^ rem_reg[top_idx];
                rem_next       = ((rem_reg << 1) & rmask) ^ (fb ? gen_w : '0);
                blk_end        = (cnt_inc == pay_w);
                if (blk_end)
                begin
                    par_mode_next = 1'b1;
                    par_left_next = r_eff;
                    blk_cnt_next  = '0;
                end
                else
                begin
                    blk_cnt_next = cnt_inc;
                end
                item_end = (info_left_reg == 4'd1) && !blk_end;
            end
        end

        // packer: pend keeps the last seven bits
        byte_done = bit_v && (pcnt_reg == 3'd7);
        new_byte  = {pend_reg, bit_val};
        if (bit_v)
        begin
            pend_next = {pend_reg[5:0], bit_val};
            pcnt_next = pcnt_reg + 1'b1;
        end
        new_v = byte_done && (out_cnt_reg < OCW'(fcbe_pkg::MAX_OUT_PER_ITEM));

        // staged byte leaves once closed or once a newer one arrives
        push_need = stg_v_reg && (stg_closed_reg || new_v);
        stall     = push_need && out_full;

        if (new_v)
        begin
            stg_byte_next   = new_byte;
            stg_v_next      = 1'b1;
            stg_closed_next = item_end;
            out_cnt_next    = out_cnt_reg + 1'b1;
        end
        else if (push_need)
        begin
            stg_v_next      = 1'b0;
            stg_closed_next = 1'b0;
        end
        else if (item_end && stg_v_reg)
        begin
            stg_closed_next = 1'b1;
        end

        // next byte comes in on the same cycle the current one ends
        ld = in_valid && (!busy_reg || item_end);
        if (ld)
        begin
            busy_next      = 1'b1;
            byte_next      = in_byte;
            info_left_next = 4'd8;
            out_cnt_next   = '0;
        end
        else if (item_end)
        begin
            busy_next = 1'b0;
        end
    end

    assign in_pop        = ld && !stall;
    assign out_push      = push_need && !out_full;
    assign out_data.code = stg_byte_reg;
    assign out_data.last = stg_closed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            byte_reg       <= '0;
            info_left_reg  <= '0;
            out_cnt_reg    <= '0;
            rem_reg        <= '0;
            blk_cnt_reg    <= '0;
            par_mode_reg   <= 1'b0;
            par_left_reg   <= '0;
            pend_reg       <= '0;
            pcnt_reg       <= '0;
            stg_byte_reg   <= '0;
            stg_v_reg      <= 1'b0;
            stg_closed_reg <= 1'b0;
        end
        else if (!stall)
        begin
            busy_reg       <= busy_next;
            byte_reg       <= byte_next;
            info_left_reg  <= info_left_next;
            out_cnt_reg    <= out_cnt_next;
            rem_reg        <= rem_next;
            blk_cnt_reg    <= blk_cnt_next;
            par_mode_reg   <= par_mode_next;
            par_left_reg   <= par_left_next;
            pend_reg       <= pend_next;
            pcnt_reg       <= pcnt_next;
            stg_byte_reg   <= stg_byte_next;
            stg_v_reg      <= stg_v_next;
            stg_closed_reg <= stg_closed_next;
        end
    end

    // a closed byte always has a byte behind it
    a_closed_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        stg_closed_reg |-> stg_v_reg)
        else $error("closed staging slot without a byte");

    // while sending parity the down counter stays nonzero and no larger than MAX_PARITY_BITS
    a_par_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        par_mode_reg |-> (par_left_reg != '0) && (par_left_reg <= PW'(MPB)))
        else $error("parity bit counter out of range");

    // information phase of a busy item always has bits left
    a_info_left: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !par_mode_reg) |-> (info_left_reg != 4'd0))
        else $error("information phase with no bits left");

    // no more than the allowed result bytes per input byte
    a_out_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= OCW'(fcbe_pkg::MAX_OUT_PER_ITEM))
        else $error("too many result bytes for one input");

    // a stalled engine holds its lfsr and its packer bit count
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> $stable(rem_reg) && $stable(pcnt_reg))
        else $error("engine state moved during a stall");

endmodule
